### rtl/rwd_pkg.sv
// shared types and codes for the range work dispatcher
`default_nettype none
package rwd_pkg;

  typedef enum logic [2:0] {
    MODE_REGISTER = 3'd0,
    MODE_EXTEND   = 3'd1,
    MODE_CLOSE    = 3'd2,
    MODE_CLAIM    = 3'd3,
    MODE_RETIRE   = 3'd4,
    MODE_OWNER    = 3'd5,
    MODE_REMOVE   = 3'd6,
    MODE_NONE     = 3'd7
  } mode_t;

  typedef enum logic [2:0] {
    ST_OK      = 3'd0,
    ST_NOCLAIM = 3'd1,
    ST_UNKNOWN = 3'd2,
    ST_FULL    = 3'd3,
    ST_BUSY    = 3'd4
  } status_code_t;

  typedef struct packed {
    logic [2:0]  mode;
    logic [7:0]  item_tag;
    logic [15:0] first_index;
    logic [15:0] range_end;
    logic [7:0]  concurrency_cap;
  } req_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [7:0]  granted_tag;
    logic [15:0] granted_index;
    logic [3:0]  live_count;
  } resp_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_LOOKUP,
    S_EXEC,
    S_DONE
  } ctrl_state_t;

  // controller commands to the datapath
  typedef struct packed {
    logic capture;
    logic lookup;
    logic exec;
    logic respond;
  } cmd_t;

endpackage : rwd_pkg
`default_nettype wire

### rtl/rwd_ctrl.sv
// controller state machine for the range work dispatcher
`default_nettype none
module rwd_ctrl
  import rwd_pkg::*;
(
  input  wire  logic clk,
  input  wire  logic rst,
  input  wire  logic start,
  output logic       busy,
  output cmd_t       cmd
);

  ctrl_state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) state <= S_IDLE;
    else     state <= state_next;
  end

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE:   if (start) state_next = S_LOOKUP;
      S_LOOKUP: state_next = S_EXEC;
      S_EXEC:   state_next = S_DONE;
      S_DONE:   state_next = S_IDLE;
      default:  state_next = S_IDLE;
    endcase
  end

  always_comb begin
    cmd  = '0;
    busy = 1'b1;
    case (state)
      S_IDLE: begin
        busy        = 1'b0;
        cmd.capture = start;
      end
      S_LOOKUP: cmd.lookup  = 1'b1;
      S_EXEC:   cmd.exec    = 1'b1;
      S_DONE:   cmd.respond = 1'b1;
      default:  busy = 1'b1;
    endcase
  end

endmodule : rwd_ctrl
`default_nettype wire

### rtl/rwd_datapath.sv
// range table, tag lookup, round-robin scan and result register
`default_nettype none
module rwd_datapath
  import rwd_pkg::*;
#(
  parameter int MAX_RANGES = 8
) (
  input  wire  logic clk,
  input  wire  logic rst,
  input  wire  req_t req,
  input  wire  cmd_t cmd,
  output resp_t      result,
  output logic       done
);

  localparam int IW = (MAX_RANGES > 1) ? $clog2(MAX_RANGES) : 1;
  localparam int CW = $clog2(MAX_RANGES + 1);

  logic [7:0]  etag  [MAX_RANGES];
  logic [15:0] enext [MAX_RANGES];
  logic [15:0] eend  [MAX_RANGES];
  logic [7:0]  eflt  [MAX_RANGES];
  logic [7:0]  ecap  [MAX_RANGES];
  logic        eopen [MAX_RANGES];
  logic [CW-1:0] count;
  logic [CW-1:0] rotor;

  req_t        r;
  logic        hit;
  logic [IW-1:0] hidx;
  logic        found;
  logic [IW-1:0] fidx;

  logic [2:0]  res_status;
  logic [7:0]  res_tag;
  logic [15:0] res_index;

  logic [MAX_RANGES-1:0] live, match, claim_ok;
  always_comb begin
    for (int i = 0; i < MAX_RANGES; i++) begin
      live[i]     = CW'(i) < count;
      match[i]    = live[i] && etag[i] == r.item_tag;
      claim_ok[i] = live[i] && eopen[i] && enext[i] < eend[i] && eflt[i] < ecap[i];
    end
  end

  // first match from slot zero, and first claimable at or after the rotor, with wrap
  logic          m_any, c_any;
  logic [IW-1:0] m_idx, c_idx;
  always_comb begin
    logic c_hi;
    logic [IW-1:0] hi_idx;
    m_any = 1'b0; m_idx = '0;
    c_any = 1'b0; c_idx = '0;
    c_hi = 1'b0;  hi_idx = '0;
    for (int i = MAX_RANGES - 1; i >= 0; i--) begin
      if (match[i]) begin m_any = 1'b1; m_idx = IW'(i); end
      if (claim_ok[i]) begin c_any = 1'b1; c_idx = IW'(i); end
      if (claim_ok[i] && CW'(i) >= rotor) begin c_hi = 1'b1; hi_idx = IW'(i); end
    end
    if (c_hi) c_idx = hi_idx;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
      rotor <= '0;
      done  <= 1'b0;
    end else begin
      done <= cmd.respond;
      if (cmd.capture) r <= req;
      if (cmd.lookup) begin
        hit   <= m_any;
        hidx  <= m_idx;
        found <= c_any;
        fidx  <= c_idx;
      end
      if (cmd.exec) begin
        res_status <= ST_OK;
        res_tag    <= '0;
        res_index  <= '0;
        case (r.mode)
          MODE_REGISTER: begin
            if (hit || count >= CW'(MAX_RANGES)) res_status <= ST_FULL;
            else begin
              etag[count[IW-1:0]]  <= r.item_tag;
              enext[count[IW-1:0]] <= r.first_index;
              eend[count[IW-1:0]]  <= r.range_end;
              eflt[count[IW-1:0]]  <= '0;
              ecap[count[IW-1:0]]  <= r.concurrency_cap;
              eopen[count[IW-1:0]] <= 1'b1;
              count <= count + 1'b1;
            end
          end
          MODE_CLAIM: begin
            if (!found) res_status <= ST_NOCLAIM;
            else begin
              res_tag     <= etag[fidx];
              res_index   <= enext[fidx];
              enext[fidx] <= enext[fidx] + 16'd1;
              eflt[fidx]  <= eflt[fidx] + 8'd1;
              rotor <= CW'(fidx) + 1'b1;
            end
          end
          MODE_NONE: res_status <= ST_OK;
          default: begin
            if (!hit) res_status <= ST_UNKNOWN;
            else begin
              case (r.mode)
                MODE_EXTEND: if (r.range_end > eend[hidx]) eend[hidx] <= r.range_end;
                MODE_CLOSE:  eopen[hidx] <= 1'b0;
                MODE_RETIRE: if (eflt[hidx] != 8'd0) eflt[hidx] <= eflt[hidx] - 8'd1;
                MODE_OWNER: begin
                  if (!claim_ok[hidx]) res_status <= ST_NOCLAIM;
                  else begin
                    res_tag     <= etag[hidx];
                    res_index   <= enext[hidx];
                    enext[hidx] <= enext[hidx] + 16'd1;
                  end
                end
                MODE_REMOVE: begin
                  if (eflt[hidx] != 8'd0) begin
                    eopen[hidx] <= 1'b0;
                    res_status  <= ST_BUSY;
                  end else begin
                    // compaction: each slot from the hit upward takes its upper neighbor
                    for (int j = 0; j < MAX_RANGES - 1; j++) begin
                      if (IW'(j) >= hidx) begin
                        etag[j]  <= etag[j+1];
                        enext[j] <= enext[j+1];
                        eend[j]  <= eend[j+1];
                        eflt[j]  <= eflt[j+1];
                        ecap[j]  <= ecap[j+1];
                        eopen[j] <= eopen[j+1];
                      end
                    end
                    count <= count - 1'b1;
                    if (rotor > count - 1'b1) rotor <= '0;
                  end
                end
                default: res_status <= ST_OK;
              endcase
            end
          end
        endcase
      end
    end
  end

  assign result = {res_status, res_tag, res_index, 4'(count)};

endmodule : rwd_datapath
`default_nettype wire

### rtl/range_work_dispatcher.sv
// top level of the range work dispatcher
//
// command-style block. a transaction is taken on a rising edge with start
// high and busy low; req carries mode, tag, first index, end bound and cap.
// every transaction gives exactly one result on resp, marked by done for
// one cycle; the receiver cannot stall it.
//
// each transaction runs capture, table lookup (tag match and
// round-robin search from the rotor), execute (table update and result
// register), then the result strobe. busy is high in the lookup, execute
// and respond states, so a new transaction is taken only once the
// controller sequence of lookup, execute and respond is back in idle.
//
// reset empties the table (live count zero) and returns the rotor to
// the first slot; table contents are left as they were and never read
// past the live count. a remove with nothing in flight shifts the upper
// entries down in the execute step, keeping table order.
`default_nettype none
module range_work_dispatcher
  import rwd_pkg::*;
#(
  parameter int MAX_RANGES = 8
) (
  input  wire  logic clk,
  input  wire  logic rst,
  input  wire  logic start,
  input  wire  req_t req,
  output logic       busy,
  output logic       done,
  output resp_t      resp
);

  cmd_t cmd;

  rwd_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .busy  (busy),
    .cmd   (cmd)
  );

  rwd_datapath #(.MAX_RANGES(MAX_RANGES)) u_dp (
    .clk    (clk),
    .rst    (rst),
    .req    (req),
    .cmd    (cmd),
    .result (resp),
    .done   (done)
  );

endmodule : range_work_dispatcher
`default_nettype wire

### bench/testbench.sv
// self-checking testbench for the range work dispatcher
`default_nettype none
module testbench;
  import rwd_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int NRANGES = 8;
  localparam int WATCHDOG_LIMIT = 20000;

  logic  clk;
  logic  rst;
  logic  start;
  req_t  req;
  logic  busy;
  logic  done;
  resp_t resp;

  range_work_dispatcher #(.MAX_RANGES(NRANGES)) dut (
    .clk(clk), .rst(rst), .start(start), .req(req),
    .busy(busy), .done(done), .resp(resp)
  );

  // predicted copy of the range table
  logic [7:0]  tbl_tag [NRANGES];
  logic [15:0] tbl_next [NRANGES];
  logic [15:0] tbl_end [NRANGES];
  logic [7:0]  tbl_flight [NRANGES];
  logic [7:0]  tbl_cap [NRANGES];
  logic        tbl_open [NRANGES];
  int          live = 0;
  int          rotor = 0;

  req_t  pending_reqs[$];
  resp_t expected_resps[$];
  int    errors = 0;
  int    idle_cycles;
  bit    stim_done = 1'b0;
  bit    drain_req = 1'b0;   // sender holds off until all results are in
  int    gap;

  // tags sent in register requests, to aim named modes at likely live ranges
  logic [7:0] known_tags[$];

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic int find_entry(logic [7:0] tag);
    for (int i = 0; i < live; i++) begin
      if (tbl_tag[i] == tag) return i;
    end
    return -1;
  endfunction

  function automatic bit can_hand_out(int i);
    return tbl_open[i] && tbl_next[i] < tbl_end[i] && tbl_flight[i] < tbl_cap[i];
  endfunction

  // compute the result of one transaction and update the predicted table
  function automatic resp_t dispatch_predict(req_t r);
    resp_t o;
    int e;
    int pos;
    mode_t m;
    m = mode_t'(r.mode);
    o = '0;
    o.status = ST_OK;
    e = -1;
    if (m != MODE_REGISTER && m != MODE_CLAIM && m != MODE_NONE) begin
      e = find_entry(r.item_tag);
      if (e < 0) o.status = ST_UNKNOWN;
    end
    case (m)
      MODE_REGISTER: begin
        if (find_entry(r.item_tag) >= 0 || live >= NRANGES) begin
          o.status = ST_FULL;
        end else begin
          tbl_tag[live] = r.item_tag;
          tbl_next[live] = r.first_index;
          tbl_end[live] = r.range_end;
          tbl_flight[live] = '0;
          tbl_cap[live] = r.concurrency_cap;
          tbl_open[live] = 1'b1;
          live++;
        end
      end
      MODE_CLAIM: begin
        o.status = ST_NOCLAIM;
        for (int k = 0; k < live; k++) begin
          pos = (rotor + k) % live;
          if (can_hand_out(pos)) begin
            o.granted_tag = tbl_tag[pos];
            o.granted_index = tbl_next[pos];
            tbl_next[pos]++;
            tbl_flight[pos]++;
            rotor = pos + 1;
            o.status = ST_OK;
            break;
          end
        end
      end
      default: begin
        if (e >= 0) begin
          case (m)
            MODE_EXTEND: if (r.range_end > tbl_end[e]) tbl_end[e] = r.range_end;
            MODE_CLOSE: tbl_open[e] = 1'b0;
            MODE_RETIRE: if (tbl_flight[e] > 0) tbl_flight[e]--;
            MODE_OWNER: begin
              if (!can_hand_out(e)) begin
                o.status = ST_NOCLAIM;
              end else begin
                o.granted_tag = tbl_tag[e];
                o.granted_index = tbl_next[e];
                tbl_next[e]++;
              end
            end
            MODE_REMOVE: begin
              tbl_open[e] = 1'b0;
              if (tbl_flight[e] > 0) begin
                o.status = ST_BUSY;
              end else begin
                for (int j = e; j + 1 < live; j++) begin
                  tbl_tag[j] = tbl_tag[j+1];
                  tbl_next[j] = tbl_next[j+1];
                  tbl_end[j] = tbl_end[j+1];
                  tbl_flight[j] = tbl_flight[j+1];
                  tbl_cap[j] = tbl_cap[j+1];
                  tbl_open[j] = tbl_open[j+1];
                end
                live--;
                if (rotor > live) rotor = 0;
              end
            end
            default: ;
          endcase
        end
      end
    endcase
    o.live_count = 4'(live);
    return o;
  endfunction

  function automatic req_t make_req(mode_t m, logic [7:0] tag, logic [15:0] first,
                                    logic [15:0] last, logic [7:0] cap);
    req_t r;
    r.mode = m;
    r.item_tag = tag;
    r.first_index = first;
    r.range_end = last;
    r.concurrency_cap = cap;
    return r;
  endfunction

  // append one transaction to the pending queue
  task automatic add_req(req_t x);
    pending_reqs = {pending_reqs, x};
  endtask

  // random transaction, mostly aimed at live tags with small ranges
  function automatic req_t random_req();
    req_t r;
    int sel;
    r = req_t'(51'({$urandom, $urandom}));
    sel = $urandom_range(0, 99);
    if (sel < 14) r.mode = MODE_REGISTER;
    else if (sel < 20) r.mode = MODE_EXTEND;
    else if (sel < 24) r.mode = MODE_CLOSE;
    else if (sel < 56) r.mode = MODE_CLAIM;
    else if (sel < 74) r.mode = MODE_RETIRE;
    else if (sel < 82) r.mode = MODE_OWNER;
    else if (sel < 97) r.mode = MODE_REMOVE;
    else r.mode = MODE_NONE;
    if (known_tags.size() > 0 && $urandom_range(0, 9) < 8) begin
      r.item_tag = known_tags[$urandom_range(0, known_tags.size() - 1)];
    end
    if (r.mode == MODE_REGISTER && $urandom_range(0, 3) != 0) begin
      // small range with low cap
      r.range_end = r.first_index + 16'($urandom_range(0, 12));
      r.concurrency_cap = 8'($urandom_range(0, 4));
      if (known_tags.size() < 24) known_tags = {known_tags, r.item_tag};
    end
    if (r.mode == MODE_EXTEND && $urandom_range(0, 1) == 1) begin
      r.range_end = 16'($urandom_range(0, 40)) + r.first_index;
    end
    return r;
  endfunction

  // fill the stimulus queue
  initial begin
    logic [15:0] hi;
    hi = 16'hffff;
    // directed: empty table cases, extremes, every mode and special case
    add_req(make_req(MODE_CLAIM, 8'h00, '0, '0, '0));
    add_req(make_req(MODE_RETIRE, 8'h55, '0, '0, '0));
    add_req(make_req(MODE_NONE, 8'hff, hi, hi, 8'hff));
    add_req(make_req(MODE_REGISTER, 8'h00, 16'h0000, hi, 8'hff));
    add_req(make_req(MODE_REGISTER, 8'hff, 16'hfffd, hi, 8'h01));
    add_req(make_req(MODE_REGISTER, 8'h00, 16'd0, 16'd5, 8'd1));
    add_req(make_req(MODE_REGISTER, 8'h10, 16'h0009, 16'h0009, 8'h02));
    add_req(make_req(MODE_CLAIM, 8'h00, '0, '0, '0));
    add_req(make_req(MODE_CLAIM, 8'h00, '0, '0, '0));
    add_req(make_req(MODE_CLAIM, 8'h00, '0, '0, '0));
    add_req(make_req(MODE_OWNER, 8'hff, '0, '0, '0));
    add_req(make_req(MODE_OWNER, 8'h00, '0, '0, '0));
    add_req(make_req(MODE_EXTEND, 8'h10, '0, 16'h0003, '0));
    add_req(make_req(MODE_EXTEND, 8'h10, '0, 16'h000b, '0));
    add_req(make_req(MODE_REMOVE, 8'hff, '0, '0, '0));
    add_req(make_req(MODE_RETIRE, 8'hff, '0, '0, '0));
    add_req(make_req(MODE_RETIRE, 8'hff, '0, '0, '0));
    add_req(make_req(MODE_CLOSE, 8'h10, '0, '0, '0));
    add_req(make_req(MODE_OWNER, 8'h10, '0, '0, '0));
    add_req(make_req(MODE_REMOVE, 8'hff, '0, '0, '0));
    add_req(make_req(MODE_REMOVE, 8'h77, '0, '0, '0));
    for (int i = 0; i < 8; i++) begin
      add_req(make_req(MODE_REGISTER, 8'(8'h20 + i), 16'd0, 16'd3, 8'd1));
    end
    for (int i = 0; i < 1650; i++) begin
      add_req(random_req());
      if (i == 800) begin
        // let the driver drain, then hold off until every result is in
        while (pending_reqs.size() > 1) @(posedge clk);
        drain_req = 1'b1;
        @(posedge clk);
        while (expected_resps.size() != 0 || start || busy) @(posedge clk);
        drain_req = 1'b0;
      end
    end
    stim_done = 1'b1;
  end

  // driver
  always @(posedge clk) begin
    if (rst) begin
      start <= 1'b0;
      req <= '0;
      gap <= 0;
    end else if (start && !busy) begin
      // transaction taken this edge
      expected_resps = {expected_resps, dispatch_predict(req)};
      start <= 1'b0;
      gap <= ($urandom_range(0, 9) < 6) ? 0 :
             ($urandom_range(0, 9) < 8) ? $urandom_range(1, 4) : $urandom_range(10, 40);
    end else if (!start) begin
      if (gap > 0) begin
        gap <= gap - 1;
      end else if (!drain_req && pending_reqs.size() > 0) begin
        req <= pending_reqs.pop_front();
        start <= 1'b1;
      end
    end
  end

  // monitor: results are single-cycle strobes, checked at the edge
  always @(posedge clk) begin
    resp_t exp_r;
    if (!rst && done) begin
      if (expected_resps.size() == 0) begin
        $error("unexpected result: status %0d", resp.status);
        errors++;
      end else begin
        exp_r = expected_resps.pop_front();
        if (resp.status !== exp_r.status) begin
          $error("status: expected %0d, got %0d", exp_r.status, resp.status);
          errors++;
        end
        if (resp.granted_tag !== exp_r.granted_tag) begin
          $error("granted_tag: expected %0h, got %0h", exp_r.granted_tag, resp.granted_tag);
          errors++;
        end
        if (resp.granted_index !== exp_r.granted_index) begin
          $error("granted_index: expected %0h, got %0h",
                 exp_r.granted_index, resp.granted_index);
          errors++;
        end
        if (resp.live_count !== exp_r.live_count) begin
          $error("live_count: expected %0d, got %0d", exp_r.live_count, resp.live_count);
          errors++;
        end
      end
    end
  end

  // watchdog: cycles with no transaction taken and no result
  always @(posedge clk) begin
    if (rst || (start && !busy) || done) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("testbench: done, errors");
        $finish;
      end
    end
  end

  initial begin
    rst = 1'b1;
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    while (!stim_done || pending_reqs.size() != 0 || start || busy ||
           expected_resps.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (errors == 0 && expected_resps.size() == 0) begin
      $display("testbench: done, clean");
    end else begin
      $display("testbench: done, errors");
    end
    $finish;
  end
endmodule
`default_nettype wire
